// ----- design/integer_to_ascii_formatter_top_defines.svh -----
// Assertion macros shared by the formatter's checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ITAF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ITAF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/itaf_pkg.sv -----
// Types, constants and helper functions of the integer to ASCII formatter.
`default_nettype none
package itaf_pkg;

    typedef enum logic [1:0] {
        FUNC_SDEC = 2'd0,
        FUNC_UDEC = 2'd1,
        FUNC_HEX  = 2'd2,
        FUNC_PTR  = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [63:0] value;
        logic        upper_case;
    } in_t;

    typedef struct packed {
        logic [7:0] character;
        logic [4:0] char_index;
        logic       last;
    } out_t;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic        is_dec;
        logic        neg;
        logic        is_ptr;
        logic        upper;
        logic [63:0] mag;
    } job_t;

    typedef enum logic [1:0] {
        BST_IDLE = 2'd0,
        BST_CONV = 2'd1,
        BST_EMIT = 2'd2
    } bst_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_UA    = 8'h41;

    // ceil(2^35 / 10): floor(v * RECIP_10 / 2^35) equals v / 10 for any 32-bit v.
    localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHFT = 35;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + d8;
        end else begin
            return (upper ? CHAR_UA : CHAR_LA) + d8 - 8'd10;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/itaf_front.sv -----
// Front end: classifies a request into sign, base, prefix and magnitude.
`default_nettype none
module itaf_front #(
    parameter int POINTER_BITS = 64
) (
    input  wire itaf_pkg::in_t  s_payload,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                push_valid,
    input  wire                 push_ready,
    output itaf_pkg::job_t      push_job
);

    localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - POINTER_BITS);

    logic [31:0] low;
    logic        neg;

    assign low        = s_payload.value[31:0];
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        neg = 1'b0;
        push_job.is_dec = 1'b0;
        push_job.is_ptr = 1'b0;
        push_job.upper  = s_payload.upper_case;
        push_job.mag    = {32'd0, low};
        case (s_payload.func)
            itaf_pkg::FUNC_SDEC: begin
                neg = low[31];
                push_job.is_dec = 1'b1;
                // The negation wraps correctly for the most negative value.
                push_job.mag = {32'd0, (low[31] ? (32'd0 - low) : low)};
            end
            itaf_pkg::FUNC_UDEC: begin
                push_job.is_dec = 1'b1;
            end
            itaf_pkg::FUNC_HEX: begin
                push_job.is_dec = 1'b0;
            end
            itaf_pkg::FUNC_PTR: begin
                push_job.is_ptr = 1'b1;
                push_job.mag    = s_payload.value & PTR_MASK;
            end
            default: begin
                push_job.is_dec = 1'b0;
            end
        endcase
        push_job.neg = neg;
    end

endmodule
`default_nettype wire

// ----- design/itaf_queue.sv -----
// Two-entry queue that decouples the front end from the back end.
`default_nettype none
module itaf_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push_valid,
    output logic                push_ready,
    input  wire itaf_pkg::job_t push_job,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output itaf_pkg::job_t      pop_job
);

    itaf_pkg::job_t                 q_mem_reg [itaf_pkg::QUEUE_DEPTH];
    logic [itaf_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [itaf_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [itaf_pkg::QUEUE_AW:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != (itaf_pkg::QUEUE_AW + 1)'(itaf_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = q_mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ----- design/itaf_back.sv -----
// Back end: converts a magnitude into digits and emits the characters in order.
`default_nettype none
module itaf_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 job_valid,
    output logic                job_ready,
    input  wire itaf_pkg::job_t job,
    output logic                m_valid,
    input  wire                 m_ready,
    output itaf_pkg::out_t      m_payload
);

    itaf_pkg::bst_t  state_reg, state_next;
    logic [63:0]     v_reg, v_next;
    logic [3:0]      n_reg, n_next;
    logic [3:0]      ptr_reg, ptr_next;
    logic [4:0]      idx_reg, idx_next;
    logic            dec_reg, dec_next;
    logic            neg_reg, neg_next;
    logic            ptrm_reg, ptrm_next;
    logic            upper_reg, upper_next;
    logic [3:0]      digit_buf_reg [16];
    logic            m_valid_reg, m_valid_next;
    itaf_pkg::out_t  m_payload_reg, m_payload_next;

    logic [63:0]     prod;
    logic [31:0]     quot;
    logic [31:0]     rem;
    logic [3:0]      digit;
    logic [63:0]     v_step;
    logic            buf_we;
    logic [4:0]      pre_len;
    logic            out_free;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign job_ready = (state_reg == itaf_pkg::BST_IDLE);

    // Decimal digits come from a reciprocal multiply, hex digits from the low nibble.
    always_comb begin
        prod   = v_reg[31:0] * itaf_pkg::RECIP_10;
        quot   = {3'b000, prod[63:itaf_pkg::RECIP_SHFT]};
        rem    = v_reg[31:0] - ((quot << 3) + (quot << 1));
        digit  = dec_reg ? rem[3:0] : v_reg[3:0];
        v_step = dec_reg ? {32'd0, quot} : {4'd0, v_reg[63:4]};
    end

    always_comb begin
        pre_len = neg_reg ? 5'd1 : (ptrm_reg ? 5'd2 : 5'd0);
    end

    always_comb begin
        state_next     = state_reg;
        v_next         = v_reg;
        n_next         = n_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        dec_next       = dec_reg;
        neg_next       = neg_reg;
        ptrm_next      = ptrm_reg;
        upper_next     = upper_reg;
        buf_we         = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        case (state_reg)
            itaf_pkg::BST_IDLE: begin
                if (job_valid) begin
                    v_next     = job.mag;
                    dec_next   = job.is_dec;
                    neg_next   = job.neg;
                    ptrm_next  = job.is_ptr;
                    upper_next = job.upper;
                    n_next     = 4'd0;
                    state_next = itaf_pkg::BST_CONV;
                end
            end
            itaf_pkg::BST_CONV: begin
                buf_we = 1'b1;
                v_next = v_step;
                if (v_step == 64'd0) begin
                    ptr_next   = n_reg;
                    idx_next   = 5'd0;
                    state_next = itaf_pkg::BST_EMIT;
                end else begin
                    n_next = n_reg + 4'd1;
                end
            end
            itaf_pkg::BST_EMIT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_payload_next.char_index = idx_reg;
                    idx_next                  = idx_reg + 5'd1;
                    if (idx_reg < pre_len) begin
                        m_payload_next.last = 1'b0;
                        if (neg_reg) begin
                            m_payload_next.character = itaf_pkg::CHAR_MINUS;
                        end else begin
                            m_payload_next.character =
                                idx_reg[0] ? itaf_pkg::CHAR_X : itaf_pkg::CHAR_ZERO;
                        end
                    end else begin
                        m_payload_next.character =
                            itaf_pkg::digit_to_ascii(digit_buf_reg[ptr_reg], upper_reg);
                        m_payload_next.last = (ptr_reg == 4'd0);
                        if (ptr_reg == 4'd0) begin
                            state_next = itaf_pkg::BST_IDLE;
                        end else begin
                            ptr_next = ptr_reg - 4'd1;
                        end
                    end
                end
            end
            default: begin
                state_next = itaf_pkg::BST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= itaf_pkg::BST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg         <= v_next;
        n_reg         <= n_next;
        ptr_reg       <= ptr_next;
        idx_reg       <= idx_next;
        dec_reg       <= dec_next;
        neg_reg       <= neg_next;
        ptrm_reg      <= ptrm_next;
        upper_reg     <= upper_next;
        m_payload_reg <= m_payload_next;
        if (buf_we) begin
            digit_buf_reg[n_reg] <= digit;
        end
    end

endmodule
`default_nettype wire

// ----- design/integer_to_ascii_formatter_top.sv -----
// Top level of the integer to ASCII formatter.
// Each request formats one integer as signed decimal, unsigned decimal, 32-bit hex or
// "0x"-prefixed pointer hex and sends one character per result, most significant first,
// with its position and a last flag. A two-entry queue sits between the classifying front
// end and the converting back end, so requests are taken while a run is still being sent.
// The back end handles one request at a time: it loads the request, then produces the
// digits (a reciprocal multiply by one tenth for decimal, a nibble shift for hex), then
// sends the characters, holding each one while the result side stalls.
`default_nettype none
module integer_to_ascii_formatter_top #(
    parameter int POINTER_BITS = 64
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire itaf_pkg::in_t  s_payload,
    output logic                m_valid,
    input  wire                 m_ready,
    output itaf_pkg::out_t      m_payload
);

    logic           push_valid, push_ready;
    itaf_pkg::job_t push_job;
    logic           pop_valid, pop_ready;
    itaf_pkg::job_t pop_job;

    itaf_front #(
        .POINTER_BITS(POINTER_BITS)
    ) u_front (
        .s_payload (s_payload),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job)
    );

    itaf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job)
    );

    itaf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(pop_valid),
        .job_ready(pop_ready),
        .job      (pop_job),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

endmodule
`default_nettype wire

// ----- design/itaf_checker.sv -----
// Port-level checker for the integer to ASCII formatter and its bind.
`default_nettype none
`include "integer_to_ascii_formatter_top_defines.svh"
module itaf_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 m_valid,
    input wire                 m_ready,
    input wire itaf_pkg::out_t m_payload
);

    // A stalled result must hold until it is taken.
    `ITAF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload), "result changed while stalled")

    // No run is longer than a pointer with sixteen digits and its prefix.
    `ITAF_ASSERT_SAME(a_index_range, aclk, aresetn, m_valid, m_payload.char_index <= 5'd17, "character position out of range")

    // A minus sign only opens a decimal run and is never the whole run.
    `ITAF_ASSERT_SAME(a_minus_first, aclk, aresetn, m_valid && (m_payload.character == itaf_pkg::CHAR_MINUS), (m_payload.char_index == 5'd0) && !m_payload.last, "minus sign misplaced")

    // The x of a pointer prefix sits second and is always followed by digits.
    `ITAF_ASSERT_SAME(a_x_second, aclk, aresetn, m_valid && (m_payload.character == itaf_pkg::CHAR_X), (m_payload.char_index == 5'd1) && !m_payload.last, "pointer prefix misplaced")

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_itaf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_payload(m_payload)
);
`default_nettype wire
